@@ sv/qsmj_pkg.sv @@
// Shared types, constants and arithmetic helpers for the quad8 surface map unit.
`default_nettype none

package qsmj_pkg;

  // Command codes of the input channel.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Coordinate store geometry: eight nodes with three axes each.
  localparam int N_NODES   = 8;
  localparam int N_AXES    = 3;
  localparam int N_ENTRIES = N_NODES * N_AXES;
  localparam int ADDR_W    = $clog2(N_ENTRIES);
  localparam int COORD_W   = 32;

  // Square root and normalization widths.
  localparam int ROOT_W = 64;
  localparam int Q_FRAC = 14;
  localparam int QUO_W  = Q_FRAC + 2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_NODE,
    ST_FIN,
    ST_CROSS,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_RUN,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_OUT
  } state_e;

  // Where a finished product is written back in the cycle after it is issued.
  typedef enum logic [3:0] {
    D_NONE,
    D_XXM,
    D_YYM,
    D_S,
    D_DX,
    D_DY,
    D_P,
    D_TX,
    D_TY,
    D_NA,
    D_NS,
    D_SQ
  } dst_kind_e;

  typedef struct packed {
    dst_kind_e  kind;
    logic [1:0] idx;
  } dst_t;

  // Control and status of the iterative units.
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Rounding shift of the shape function numerators.
  function automatic logic [4:0] shp_shift(input logic [2:0] nd);
    return nd[2] ? 5'd19 : 5'd20;
  endfunction

  // Rounding shift of the xi derivative numerators.
  function automatic logic [4:0] dxi_shift(input logic [2:0] nd);
    return nd[2] ? (nd[0] ? 5'd5 : 5'd4) : 5'd6;
  endfunction

  // Rounding shift of the eta derivative numerators.
  function automatic logic [4:0] deta_shift(input logic [2:0] nd);
    return nd[2] ? (nd[0] ? 5'd4 : 5'd5) : 5'd6;
  endfunction

  // Arithmetic shift right with rounding half away from zero; sh is at least one.
  function automatic logic signed [71:0] rnd_haz(input logic signed [71:0] v,
                                                 input logic [4:0] sh);
    logic [71:0] m;
    logic [71:0] half;
    m    = v[71] ? 72'(-v) : 72'(v);
    half = 72'd1 << (sh - 5'd1);
    m    = (m + half) >> sh;
    return v[71] ? -signed'(m) : signed'(m);
  endfunction

  // Saturation to 32 bits, either two's complement range or symmetric range.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v,
                                               input logic sym);
    logic signed [71:0] lo;
    logic signed [71:0] hi;
    hi = 72'sd2147483647;
    lo = sym ? -72'sd2147483647 : -72'sd2147483648;
    if (v < lo) begin
      return lo[31:0];
    end else if (v > hi) begin
      return hi[31:0];
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/qsmj_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module qsmj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ sv/qsmj_sqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module qsmj_sqrt
  import qsmj_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  unit_ctl_t             ctl_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output unit_sts_t             sts_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int CntW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W+1:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [ROOT_W+3:0] rem_t;
  logic [ROOT_W+3:0] trial;
  logic [ROOT_W+3:0] diff;
  logic              ge;

  // One restoring root digit: bring down two bits and try the next root bit.
  assign rem_t = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = rem_t >= trial;

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, root and radicand shift register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
      rem_q  <= ge ? diff[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = root_q;

endmodule

`default_nettype wire

@@ sv/qsmj_div.sv @@
// Bit-serial divider that forms a normal component in Q1.14 with rounding.
`default_nettype none

module qsmj_div
  import qsmj_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  unit_ctl_t               ctl_i,
  input  logic signed [ROOT_W-1:0] num_i,
  input  logic [ROOT_W-1:0]       den_i,
  output unit_sts_t               sts_o,
  output logic signed [QUO_W-1:0] quotient_o
);

  localparam int StepW = $clog2(Q_FRAC + 2);

  logic [ROOT_W:0]    rem_q;
  logic [ROOT_W-1:0]  den_q;
  logic [QUO_W-1:0]   q_q;
  logic               neg_q;
  logic [StepW-1:0]   step_q;
  logic               busy_q;
  logic               done_q;

  logic [ROOT_W:0]   sh;
  logic [ROOT_W:0]   diff;
  logic              ge;
  logic              last;
  logic [ROOT_W-1:0] num_mag;

  assign num_mag = num_i[ROOT_W-1] ? ROOT_W'(-num_i) : ROOT_W'(num_i);

  // The first step compares the magnitude as it is; the others shift in a zero.
  assign sh   = (step_q == '0) ? rem_q : {rem_q[ROOT_W-1:0], 1'b0};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};
  assign last = step_q == StepW'(Q_FRAC + 1);

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder; the last step only rounds.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= {1'b0, num_mag};
      den_q <= den_i;
      neg_q <= num_i[ROOT_W-1];
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff : sh;
      if (last) begin
        q_q <= q_q + QUO_W'(ge);
      end else begin
        q_q <= {q_q[QUO_W-2:0], ge};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = neg_q ? -signed'(q_q) : signed'(q_q);

endmodule

`default_nettype wire

@@ sv/quad8_surface_map_jacobian_unit.sv @@
// Eight-node serendipity surface element: mapped point, Jacobian and unit normal.
//
// Input channel (in_valid_i / in_stall_o): a transaction is taken when valid is
// high and stall is low. A load transaction writes one node coordinate into the
// coordinate RAM and gives no result. An evaluate transaction runs the
// sequencer: setup, then each node in turn over one shared multiplier, then
// tangents, cross product and squares, the bit-serial square root and, once
// per normal component, the bit-serial divider, which is skipped when the
// cross product is zero. Only one evaluation is in flight; stall is high
// while it runs.
// Output channel (out_valid_o / out_stall_i): each evaluation gives one result
// transaction held in an output register. While the receiver stalls, the result
// holds and loads are still taken; a following evaluation waits in its last
// state until the register frees up.
// Reset clears the sequencer and the output valid. The coordinate RAM is not
// cleared; every entry must be loaded before the first evaluation.
`default_nettype none

module quad8_surface_map_jacobian_unit
  import qsmj_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [2:0]         node_index_i,
  input  logic [1:0]         axis_i,
  input  logic signed [31:0] coord_value_i,
  input  logic signed [15:0] xi_i,
  input  logic signed [15:0] eta_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic [47:0]        jacobian_o,
  output logic               degenerate_o
);

  typedef struct packed {
    logic signed [35:0] f1;
    logic signed [35:0] f2;
    logic signed [35:0] f3;
    logic signed [35:0] g1;
    logic signed [35:0] g2;
    logic signed [35:0] h1;
    logic signed [35:0] h2;
  } fac_t;

  // Factors of the shape function and derivative numerators of one node.
  function automatic fac_t node_fac(input logic [2:0] nd, input logic signed [35:0] x,
                                    input logic signed [35:0] y,
                                    input logic signed [35:0] xxm,
                                    input logic signed [35:0] yym);
    logic signed [35:0] o;
    logic signed [35:0] xm;
    logic signed [35:0] xp;
    logic signed [35:0] ym;
    logic signed [35:0] yp;
    fac_t f;
    o  = 36'sd16384;
    xm = o - x;
    xp = o + x;
    ym = o - y;
    yp = o + y;
    f  = '0;
    case (nd)
      3'd0: begin
        f.f1 = xm;  f.f2 = ym;  f.f3 = -o - x - y;
        f.g1 = ym;  f.g2 = x + x + y;
        f.h1 = xm;  f.h2 = x + y + y;
      end
      3'd1: begin
        f.f1 = xp;  f.f2 = ym;  f.f3 = -o + x - y;
        f.g1 = ym;  f.g2 = x + x - y;
        f.h1 = xp;  f.h2 = y + y - x;
      end
      3'd2: begin
        f.f1 = xp;  f.f2 = yp;  f.f3 = -o + x + y;
        f.g1 = yp;  f.g2 = x + x + y;
        f.h1 = xp;  f.h2 = x + y + y;
      end
      3'd3: begin
        f.f1 = xm;  f.f2 = yp;  f.f3 = -o - x + y;
        f.g1 = yp;  f.g2 = x + x - y;
        f.h1 = xm;  f.h2 = y + y - x;
      end
      3'd4: begin
        f.f1 = xxm; f.f2 = 36'sd1; f.f3 = ym;
        f.g1 = -x;  f.g2 = ym;
        f.h1 = -xxm; f.h2 = 36'sd1;
      end
      3'd5: begin
        f.f1 = yym; f.f2 = 36'sd1; f.f3 = xp;
        f.g1 = yym; f.g2 = 36'sd1;
        f.h1 = -y;  f.h2 = xp;
      end
      3'd6: begin
        f.f1 = xxm; f.f2 = 36'sd1; f.f3 = yp;
        f.g1 = -x;  f.g2 = yp;
        f.h1 = xxm; f.h2 = 36'sd1;
      end
      default: begin
        f.f1 = yym; f.f2 = 36'sd1; f.f3 = xm;
        f.g1 = -yym; f.g2 = 36'sd1;
        f.h1 = -y;  f.h2 = xm;
      end
    endcase
    return f;
  endfunction

  function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
    return signed'({{4{v[31]}}, v});
  endfunction

  // Sequencer state.
  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [2:0] node_q, node_d;
  logic [1:0] comp_q, comp_d;
  dst_t       dst_q, dst_d;

  // Data registers.
  logic signed [15:0] xi_q, eta_q;
  logic signed [31:0] xxm_q, yym_q;
  logic signed [71:0] prod_q;
  logic signed [31:0] s_q, dx_q, dy_q;
  logic signed [31:0] c_q [N_AXES];
  logic signed [67:0] pacc_q [N_AXES];
  logic signed [67:0] tx_q [N_AXES];
  logic signed [67:0] ty_q [N_AXES];
  logic signed [31:0] pos_q [N_AXES];
  logic signed [31:0] a_q [N_AXES];
  logic signed [31:0] b_q [N_AXES];
  logic signed [63:0] n_q [N_AXES];
  logic [127:0]       sum_q;
  logic               degen_q;
  logic signed [15:0] nrm_q [N_AXES];

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_pos_q [N_AXES];
  logic signed [15:0] out_nrm_q [N_AXES];
  logic [47:0]        out_jac_q;
  logic               out_degen_q;

  // Control decoded each cycle.
  logic               in_accept;
  logic               eval_start;
  logic               acc_clear;
  logic               fin_en;
  logic               nrm_clear;
  logic               nrm_store;
  logic               out_load;
  logic               out_free;
  logic signed [35:0] op_a, op_b;
  logic               rd_en;
  logic [1:0]         rd_axis;
  logic [1:0]         c_idx;
  logic               c_load;
  logic [1:0]         mac_axis;
  logic [1:0]         mac_sel;
  logic [1:0]         sq_comp;
  logic [1:0]         sq_part;
  logic [63:0]        sq_mag;
  logic [127:0]       sq_term;
  fac_t               fac;

  // Memory ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [COORD_W-1:0]  ram_rdata;

  // Iterative units.
  unit_ctl_t          sqrt_ctl, div_ctl;
  unit_sts_t          sqrt_sts, div_sts;
  logic [ROOT_W-1:0]  root;
  logic signed [QUO_W-1:0] quotient;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Load transactions go straight into the coordinate RAM; axis three is dropped.
  assign ram_we    = in_accept && (command_i == CMD_LOAD) && (axis_i < 2'(N_AXES));
  assign ram_waddr = ({2'b00, node_index_i} << 1) + {2'b00, node_index_i} + {3'b000, axis_i};
  assign ram_raddr = ({2'b00, node_q} << 1) + {2'b00, node_q} + {3'b000, rd_axis};

  assign rd_axis = step_q[1:0] - 2'd2;
  assign c_idx   = step_q[1:0] - 2'd3;
  assign c_load  = (state_q == ST_NODE) && (step_q >= 4'd3) && (step_q <= 4'd5);

  assign fac = node_fac(node_q, ext36(32'(xi_q)), ext36(32'(eta_q)), ext36(xxm_q),
                        ext36(yym_q));

  // Multiply-accumulate slots of a node: three axes times shape, dxi, deta.
  always_comb begin
    mac_axis = 2'd0;
    mac_sel  = 2'd0;
    case (step_q)
      4'd4:    begin mac_axis = 2'd0; mac_sel = 2'd0; end
      4'd5:    begin mac_axis = 2'd0; mac_sel = 2'd1; end
      4'd6:    begin mac_axis = 2'd0; mac_sel = 2'd2; end
      4'd7:    begin mac_axis = 2'd1; mac_sel = 2'd0; end
      4'd8:    begin mac_axis = 2'd1; mac_sel = 2'd1; end
      4'd9:    begin mac_axis = 2'd1; mac_sel = 2'd2; end
      4'd10:   begin mac_axis = 2'd2; mac_sel = 2'd0; end
      4'd11:   begin mac_axis = 2'd2; mac_sel = 2'd1; end
      4'd12:   begin mac_axis = 2'd2; mac_sel = 2'd2; end
      default: ;
    endcase
  end

  // Square slots: three partial products for each cross product component.
  always_comb begin
    sq_comp = 2'd0;
    sq_part = 2'd0;
    case (step_q)
      4'd0:    begin sq_comp = 2'd0; sq_part = 2'd0; end
      4'd1:    begin sq_comp = 2'd0; sq_part = 2'd1; end
      4'd2:    begin sq_comp = 2'd0; sq_part = 2'd2; end
      4'd3:    begin sq_comp = 2'd1; sq_part = 2'd0; end
      4'd4:    begin sq_comp = 2'd1; sq_part = 2'd1; end
      4'd5:    begin sq_comp = 2'd1; sq_part = 2'd2; end
      4'd6:    begin sq_comp = 2'd2; sq_part = 2'd0; end
      4'd7:    begin sq_comp = 2'd2; sq_part = 2'd1; end
      4'd8:    begin sq_comp = 2'd2; sq_part = 2'd2; end
      default: ;
    endcase
  end

  assign sq_mag = n_q[sq_comp][63] ? 64'(-n_q[sq_comp]) : 64'(n_q[sq_comp]);

  // Shifted square term written back to the sum of squares.
  always_comb begin
    case (dst_q.idx)
      2'd0:    sq_term = {64'b0, prod_q[63:0]};
      2'd1:    sq_term = {31'b0, prod_q[63:0], 33'b0};
      default: sq_term = {prod_q[63:0], 64'b0};
    endcase
  end

  // Next state, multiplier operands and write-back tags.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    node_d     = node_q;
    comp_d     = comp_q;
    dst_d      = '{kind: D_NONE, idx: 2'd0};
    op_a       = '0;
    op_b       = '0;
    rd_en      = 1'b0;
    eval_start = 1'b0;
    acc_clear  = 1'b0;
    fin_en     = 1'b0;
    nrm_clear  = 1'b0;
    nrm_store  = 1'b0;
    out_load   = 1'b0;
    sqrt_ctl   = '{start: 1'b0};
    div_ctl    = '{start: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (command_i == CMD_EVAL)) begin
          eval_start = 1'b1;
          state_d    = ST_INIT;
          step_d     = 4'd0;
        end
      end
      ST_INIT: begin
        acc_clear = 1'b1;
        if (step_q == 4'd0) begin
          op_a   = ext36(32'(xi_q));
          op_b   = ext36(32'(xi_q));
          dst_d  = '{kind: D_XXM, idx: 2'd0};
          step_d = 4'd1;
        end else begin
          op_a    = ext36(32'(eta_q));
          op_b    = ext36(32'(eta_q));
          dst_d   = '{kind: D_YYM, idx: 2'd0};
          state_d = ST_NODE;
          step_d  = 4'd0;
          node_d  = 3'd0;
        end
      end
      ST_NODE: begin
        rd_en = (step_q >= 4'd2) && (step_q <= 4'd4);
        case (step_q)
          4'd0: begin
            op_a = fac.f1;
            op_b = fac.f2;
          end
          4'd1: begin
            op_a  = prod_q[35:0];
            op_b  = fac.f3;
            dst_d = '{kind: D_S, idx: 2'd0};
          end
          4'd2: begin
            op_a  = fac.g1;
            op_b  = fac.g2;
            dst_d = '{kind: D_DX, idx: 2'd0};
          end
          4'd3: begin
            op_a  = fac.h1;
            op_b  = fac.h2;
            dst_d = '{kind: D_DY, idx: 2'd0};
          end
          default: begin
            op_b = ext36(c_q[mac_axis]);
            case (mac_sel)
              2'd0: begin
                op_a  = ext36(s_q);
                dst_d = '{kind: D_P, idx: mac_axis};
              end
              2'd1: begin
                op_a  = ext36(dx_q);
                dst_d = '{kind: D_TX, idx: mac_axis};
              end
              default: begin
                op_a  = ext36(dy_q);
                dst_d = '{kind: D_TY, idx: mac_axis};
              end
            endcase
          end
        endcase
        if (step_q == 4'd12) begin
          step_d = 4'd0;
          if (node_q == 3'(N_NODES - 1)) begin
            state_d = ST_FIN;
          end else begin
            node_d = node_q + 3'd1;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_FIN: begin
        if (dst_q.kind == D_NONE) begin
          fin_en  = 1'b1;
          state_d = ST_CROSS;
          step_d  = 4'd0;
        end
      end
      ST_CROSS: begin
        case (step_q)
          4'd0: begin
            op_a = ext36(a_q[1]); op_b = ext36(b_q[2]);
            dst_d = '{kind: D_NA, idx: 2'd0};
          end
          4'd1: begin
            op_a = ext36(a_q[2]); op_b = ext36(b_q[1]);
            dst_d = '{kind: D_NS, idx: 2'd0};
          end
          4'd2: begin
            op_a = ext36(a_q[2]); op_b = ext36(b_q[0]);
            dst_d = '{kind: D_NA, idx: 2'd1};
          end
          4'd3: begin
            op_a = ext36(a_q[0]); op_b = ext36(b_q[2]);
            dst_d = '{kind: D_NS, idx: 2'd1};
          end
          4'd4: begin
            op_a = ext36(a_q[0]); op_b = ext36(b_q[1]);
            dst_d = '{kind: D_NA, idx: 2'd2};
          end
          default: begin
            op_a = ext36(a_q[1]); op_b = ext36(b_q[0]);
            dst_d = '{kind: D_NS, idx: 2'd2};
          end
        endcase
        if (step_q == 4'd5) begin
          state_d = ST_SQ;
          step_d  = 4'd0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_SQ: begin
        // Low word times low word, cross term, high word times high word.
        case (sq_part)
          2'd0: begin
            op_a = signed'({4'b0, sq_mag[31:0]});
            op_b = signed'({4'b0, sq_mag[31:0]});
          end
          2'd1: begin
            op_a = signed'({4'b0, sq_mag[63:32]});
            op_b = signed'({4'b0, sq_mag[31:0]});
          end
          default: begin
            op_a = signed'({4'b0, sq_mag[63:32]});
            op_b = signed'({4'b0, sq_mag[63:32]});
          end
        endcase
        dst_d = '{kind: D_SQ, idx: sq_part};
        if (step_q == 4'd8) begin
          state_d = ST_ROOT_GO;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_ROOT_GO: begin
        if (dst_q.kind == D_NONE) begin
          sqrt_ctl  = '{start: 1'b1};
          nrm_clear = 1'b1;
          state_d   = ST_ROOT_RUN;
        end
      end
      ST_ROOT_RUN: begin
        if (sqrt_sts.done) begin
          comp_d  = 2'd0;
          state_d = degen_q ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_ctl = '{start: 1'b1};
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_sts.done) begin
          nrm_store = 1'b1;
          if (comp_q == 2'(N_AXES - 1)) begin
            state_d = ST_OUT;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 4'd0;
      node_q  <= 3'd0;
      comp_q  <= 2'd0;
      dst_q   <= '{kind: D_NONE, idx: 2'd0};
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      node_q  <= node_d;
      comp_q  <= comp_d;
      dst_q   <= dst_d;
    end
  end

  // Shared multiplier, the write-back of its registered product, and the phase results.
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (eval_start) begin
      xi_q  <= xi_i;
      eta_q <= eta_i;
    end
    if (c_load) begin
      c_q[c_idx] <= signed'(ram_rdata);
    end
    if (acc_clear) begin
      for (int k = 0; k < N_AXES; k++) begin
        pacc_q[k] <= '0;
        tx_q[k]   <= '0;
        ty_q[k]   <= '0;
      end
    end
    case (dst_q.kind)
      D_XXM: xxm_q <= 32'sd268435456 - signed'(prod_q[31:0]);
      D_YYM: yym_q <= 32'sd268435456 - signed'(prod_q[31:0]);
      D_S:   s_q   <= 32'(rnd_haz(prod_q, shp_shift(node_q)));
      D_DX:  dx_q  <= 32'(rnd_haz(prod_q, dxi_shift(node_q)));
      D_DY:  dy_q  <= 32'(rnd_haz(prod_q, deta_shift(node_q)));
      D_P:   pacc_q[dst_q.idx] <= pacc_q[dst_q.idx] + {{4{prod_q[63]}}, prod_q[63:0]};
      D_TX:  tx_q[dst_q.idx]   <= tx_q[dst_q.idx] + {{4{prod_q[63]}}, prod_q[63:0]};
      D_TY:  ty_q[dst_q.idx]   <= ty_q[dst_q.idx] + {{4{prod_q[63]}}, prod_q[63:0]};
      D_NA:  n_q[dst_q.idx]    <= signed'(prod_q[63:0]);
      D_NS:  n_q[dst_q.idx]    <= n_q[dst_q.idx] - signed'(prod_q[63:0]);
      D_SQ:  sum_q             <= sum_q + sq_term;
      default: ;
    endcase
    // Position and tangents rounded to Q16.16 once all nodes are summed.
    if (fin_en) begin
      for (int k = 0; k < N_AXES; k++) begin
        pos_q[k] <= sat32(rnd_haz({{4{pacc_q[k][67]}}, pacc_q[k]}, 5'd24), 1'b0);
        a_q[k]   <= sat32(rnd_haz({{4{tx_q[k][67]}}, tx_q[k]}, 5'd24), 1'b1);
        b_q[k]   <= sat32(rnd_haz({{4{ty_q[k][67]}}, ty_q[k]}, 5'd24), 1'b1);
      end
      sum_q <= '0;
    end
    if (nrm_clear) begin
      degen_q <= sum_q == '0;
      for (int k = 0; k < N_AXES; k++) begin
        nrm_q[k] <= '0;
      end
    end
    if (nrm_store) begin
      nrm_q[comp_q] <= quotient;
    end
  end

  // Output register: valid is control, the payload loads with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int k = 0; k < N_AXES; k++) begin
        out_pos_q[k] <= pos_q[k];
        out_nrm_q[k] <= nrm_q[k];
      end
      out_jac_q   <= root[63:16];
      out_degen_q <= degen_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pos_x_o      = out_pos_q[0];
  assign pos_y_o      = out_pos_q[1];
  assign pos_z_o      = out_pos_q[2];
  assign normal_x_o   = out_nrm_q[0];
  assign normal_y_o   = out_nrm_q[1];
  assign normal_z_o   = out_nrm_q[2];
  assign jacobian_o   = out_jac_q;
  assign degenerate_o = out_degen_q;

  // Node coordinate store.
  qsmj_ram #(
    .WIDTH (COORD_W),
    .DEPTH (N_ENTRIES)
  ) u_coord_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (coord_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Jacobian magnitude.
  qsmj_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sqrt_ctl),
    .radicand_i (sum_q),
    .sts_o      (sqrt_sts),
    .root_o     (root)
  );

  // Normal components, one after another.
  qsmj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .num_i      (n_q[comp_q]),
    .den_i      (root),
    .sts_o      (div_sts),
    .quotient_o (quotient)
  );

  // A degenerate result carries a zero normal and a zero Jacobian.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> jacobian_o == '0 && normal_x_o == '0 &&
                                    normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate result with nonzero normal or jacobian");

  // Normal components never exceed one in magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
                    normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384 &&
                    normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384)
    else $error("normal component out of range");

  // No product write-back is left pending once the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> dst_q.kind == D_NONE)
    else $error("pending write-back in idle");

  // The square root unit is running or finishing while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT_RUN |-> sqrt_sts.busy || sqrt_sts.done)
    else $error("waiting on an idle square root unit");

  // The divider is running or finishing while the sequencer waits on it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_RUN |-> div_sts.busy || div_sts.done)
    else $error("waiting on an idle divider");

endmodule

`default_nettype wire
